// File: rtl/core/epp_pkg.sv
// Shared types, codes and sizing constants for the expression precedence parser.
// Used by epp_ctrl, epp_datapath and expression_precedence_parser; no dependencies.
package epp_pkg;

    // Sizing
    localparam int MAX_NODES = 1024;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int IDX_W     = 10;
    localparam int POS_W     = 16;
    localparam int TKIND_W   = 3;
    localparam int NKIND_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int PCNT_W    = 2;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 56;

    // Input token kinds (five to seven behave as "other")
    localparam logic [TKIND_W-1:0] TOK_INT   = 3'd0;
    localparam logic [TKIND_W-1:0] TOK_PLUS  = 3'd1;
    localparam logic [TKIND_W-1:0] TOK_MINUS = 3'd2;
    localparam logic [TKIND_W-1:0] TOK_STAR  = 3'd3;
    localparam logic [TKIND_W-1:0] TOK_SLASH = 3'd4;

    // Node kinds on the result channel
    localparam logic [NKIND_W-1:0] NODE_INT = 3'd0;

    // Pending operator codes; node kind is the code plus one
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Binding strength
    localparam logic [4:0] PREC_ADD = 5'd10;
    localparam logic [4:0] PREC_MUL = 5'd20;

    typedef enum logic [STATUS_W-1:0] {
        ST_NODE     = 2'd0,
        ST_DONE     = 2'd1,
        ST_EXPECTED = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_LEAF      = 3'd1,
        CMD_ERROR     = 3'd2,
        CMD_OVF_TOKEN = 3'd3,
        CMD_REDUCE    = 3'd4,
        CMD_OVF_TOP   = 3'd5,
        CMD_DONE      = 3'd6,
        CMD_PUSH_OP   = 3'd7
    } cmd_op_t;

    typedef struct packed {
        logic    load;
        cmd_op_t op;
        logic    last;
    } epp_cmd_t;

    typedef struct packed {
        logic expect_operand;
        logic is_literal;
        logic is_op;
        logic pending_any;
        logic reduce_top;
        logic reduce_next;
        logic counter_full;
        logic out_free;
    } epp_status_t;

    function automatic logic [4:0] op_prec(input logic [1:0] op);
        logic [4:0] prec;
        prec = (op == OP_MUL || op == OP_DIV) ? PREC_MUL : PREC_ADD;
        return prec;
    endfunction

endpackage

// File: rtl/core/epp_ctrl.sv
// Controller state machine for the expression precedence parser.
// Depends on epp_pkg; drives epp_datapath through command and status structs.
module epp_ctrl
    import epp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  epp_status_t dp_status,
    output epp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence one token: take it, then step through reductions and results
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        dp_cmd.load = 1'b0;
        dp_cmd.op   = CMD_NONE;
        dp_cmd.last = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (dp_status.expect_operand) begin
                    // Operand position: literal, error or overflow, always one result
                    if (dp_status.out_free) begin
                        if (!dp_status.is_literal) begin
                            dp_cmd.op = CMD_ERROR;
                        end else if (dp_status.counter_full) begin
                            dp_cmd.op = CMD_OVF_TOKEN;
                        end else begin
                            dp_cmd.op = CMD_LEAF;
                        end
                        dp_cmd.last = 1'b1;
                        state_next  = S_IDLE;
                    end
                end else if (dp_status.is_op) begin
                    // Operator: reduce tighter-or-equal pending operators, then push
                    if (dp_status.reduce_top) begin
                        if (dp_status.out_free) begin
                            if (dp_status.counter_full) begin
                                dp_cmd.op   = CMD_OVF_TOP;
                                dp_cmd.last = 1'b1;
                                state_next  = S_IDLE;
                            end else begin
                                dp_cmd.op   = CMD_REDUCE;
                                dp_cmd.last = !dp_status.reduce_next;
                            end
                        end
                    end else begin
                        dp_cmd.op  = CMD_PUSH_OP;
                        state_next = S_IDLE;
                    end
                end else begin
                    // End of expression: reduce everything, then report done
                    if (dp_status.out_free) begin
                        if (dp_status.pending_any) begin
                            if (dp_status.counter_full) begin
                                dp_cmd.op   = CMD_OVF_TOP;
                                dp_cmd.last = 1'b1;
                                state_next  = S_IDLE;
                            end else begin
                                dp_cmd.op = CMD_REDUCE;
                            end
                        end else begin
                            dp_cmd.op   = CMD_DONE;
                            dp_cmd.last = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/epp_datapath.sv
// Datapath for the expression precedence parser: token register, stacks,
// node counter and result register. Depends on epp_pkg; commanded by epp_ctrl.
module epp_datapath
    import epp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             m_tlast,
    input  epp_cmd_t         dp_cmd,
    output epp_status_t      dp_status
);

    // Current token
    logic [TKIND_W-1:0] tok_kind_reg;
    logic [POS_W-1:0]   tok_pos_reg;

    // Parser state; stacks keep their top at entry zero
    logic               expect_reg;
    logic [1:0]         pend_kind_reg [2];
    logic [POS_W-1:0]   pend_tok_reg  [2];
    logic [PCNT_W-1:0]  pend_cnt_reg;
    logic [IDX_W-1:0]   opnd_reg      [3];
    logic [CNT_W-1:0]   node_cnt_reg;

    // Result register
    logic               out_valid_reg;
    logic               out_last_reg;
    status_t            out_status_reg;
    logic [NKIND_W-1:0] out_kind_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [POS_W-1:0]   out_token_reg;
    logic [IDX_W-1:0]   out_left_reg;
    logic [IDX_W-1:0]   out_right_reg;

    logic [1:0]         new_op;
    logic [4:0]         new_prec;
    logic [IDX_W-1:0]   node_idx;
    logic               emit;
    logic               clear;

    assign new_op   = 2'(tok_kind_reg - TOK_PLUS);
    assign new_prec = op_prec(new_op);
    assign node_idx = IDX_W'(node_cnt_reg);

    // Report status to the controller
    always_comb begin
        dp_status.expect_operand = expect_reg;
        dp_status.is_literal     = (tok_kind_reg == TOK_INT);
        dp_status.is_op          = (tok_kind_reg == TOK_PLUS) || (tok_kind_reg == TOK_MINUS)
                                 || (tok_kind_reg == TOK_STAR) || (tok_kind_reg == TOK_SLASH);
        dp_status.pending_any    = (pend_cnt_reg != '0);
        dp_status.reduce_top     = (pend_cnt_reg != '0)
                                 && (op_prec(pend_kind_reg[0]) >= new_prec);
        dp_status.reduce_next    = (pend_cnt_reg == PCNT_W'(2))
                                 && (op_prec(pend_kind_reg[1]) >= new_prec);
        dp_status.counter_full   = (node_cnt_reg >= CNT_W'(MAX_NODES));
        dp_status.out_free       = !out_valid_reg || m_tready;
    end

    assign emit  = (dp_cmd.op != CMD_NONE) && (dp_cmd.op != CMD_PUSH_OP);
    assign clear = (dp_cmd.op == CMD_ERROR) || (dp_cmd.op == CMD_OVF_TOKEN)
                || (dp_cmd.op == CMD_OVF_TOP) || (dp_cmd.op == CMD_DONE);

    // Capture the token on its transaction
    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            tok_kind_reg <= s_tdata[TKIND_W-1:0];
            tok_pos_reg  <= s_tdata[TKIND_W +: POS_W];
        end
    end

    // Control state of the parser
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_reg   <= 1'b1;
            pend_cnt_reg <= '0;
            node_cnt_reg <= '0;
        end else if (clear) begin
            expect_reg   <= 1'b1;
            pend_cnt_reg <= '0;
            node_cnt_reg <= '0;
        end else begin
            case (dp_cmd.op)
                CMD_LEAF: begin
                    expect_reg   <= 1'b0;
                    node_cnt_reg <= node_cnt_reg + CNT_W'(1);
                end
                CMD_REDUCE: begin
                    pend_cnt_reg <= pend_cnt_reg - PCNT_W'(1);
                    node_cnt_reg <= node_cnt_reg + CNT_W'(1);
                end
                CMD_PUSH_OP: begin
                    expect_reg <= 1'b1;
                    if (pend_cnt_reg < PCNT_W'(2)) begin
                        pend_cnt_reg <= pend_cnt_reg + PCNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Stack contents: shift on push, pull up on pop
    always_ff @(posedge aclk) begin
        case (dp_cmd.op)
            CMD_LEAF: begin
                opnd_reg[0] <= node_idx;
                opnd_reg[1] <= opnd_reg[0];
                opnd_reg[2] <= opnd_reg[1];
            end
            CMD_REDUCE: begin
                opnd_reg[0]      <= node_idx;
                opnd_reg[1]      <= opnd_reg[2];
                pend_kind_reg[0] <= pend_kind_reg[1];
                pend_tok_reg[0]  <= pend_tok_reg[1];
            end
            CMD_PUSH_OP: begin
                if (pend_cnt_reg < PCNT_W'(2)) begin
                    pend_kind_reg[0] <= new_op;
                    pend_tok_reg[0]  <= tok_pos_reg;
                    pend_kind_reg[1] <= pend_kind_reg[0];
                    pend_tok_reg[1]  <= pend_tok_reg[0];
                end
            end
            default: begin
            end
        endcase
    end

    // Result valid: set on a new result, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_last_reg   <= dp_cmd.last;
            out_status_reg <= ST_NODE;
            out_kind_reg   <= NODE_INT;
            out_index_reg  <= '0;
            out_token_reg  <= '0;
            out_left_reg   <= '0;
            out_right_reg  <= '0;
            case (dp_cmd.op)
                CMD_LEAF: begin
                    out_index_reg <= node_idx;
                    out_token_reg <= tok_pos_reg;
                end
                CMD_ERROR: begin
                    out_status_reg <= ST_EXPECTED;
                    out_token_reg  <= tok_pos_reg;
                end
                CMD_OVF_TOKEN: begin
                    out_status_reg <= ST_OVERFLOW;
                    out_token_reg  <= tok_pos_reg;
                end
                CMD_REDUCE: begin
                    out_kind_reg  <= NKIND_W'(pend_kind_reg[0]) + NKIND_W'(1);
                    out_index_reg <= node_idx;
                    out_token_reg <= pend_tok_reg[0];
                    out_left_reg  <= opnd_reg[1];
                    out_right_reg <= opnd_reg[0];
                end
                CMD_OVF_TOP: begin
                    out_status_reg <= ST_OVERFLOW;
                    out_token_reg  <= pend_tok_reg[0];
                end
                CMD_DONE: begin
                    out_status_reg <= ST_DONE;
                end
                default: begin
                end
            endcase
        end
    end

    // Pack the result transaction
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_right_reg, out_left_reg, out_token_reg, out_index_reg,
                       out_kind_reg, out_status_reg};

endmodule

// File: rtl/core/expression_precedence_parser.sv
// Top level of the expression precedence parser: stream ports, controller and datapath.
// Depends on epp_pkg, epp_ctrl and epp_datapath.
//
//   Port group  Direction  Carries
//   s_          in         one token per transaction
//   m_          out        one parse node or event per transaction, tlast on each token's last one
//
// A token is taken in S_IDLE and then handled in S_EXEC at one result per cycle while the
// result register is free: a literal or an error gives one, an operator one per reduction
// before its push (which gives none), an end token one per reduction plus one for done.
// The controller sequences one token at a time; the result register lets the next
// token in while the last result still waits. A stall on m_tready holds the controller
// in place. Reset (aresetn low, synchronous) empties both stacks and zeroes the node count.
module expression_precedence_parser
    import epp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // token_kind[2:0], token_position[18:3], zeros above
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // status[1:0], node_kind[4:2], node_index[14:5],
                                        // node_token[30:15], left_child[40:31],
                                        // right_child[50:41], zeros above
    output logic             m_tlast
);

    epp_cmd_t    dp_cmd;
    epp_status_t dp_status;

    // Sequence tokens
    epp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // Hold stacks, counter and the result register
    epp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

endmodule
